@@ src/keyed_record_hash_table_unit_defines.svh @@
// Assertion macros shared by the keyed record hash table unit.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef KEYED_RECORD_HASH_TABLE_UNIT_DEFINES_SVH
`define KEYED_RECORD_HASH_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define KHTU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KHTU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/khtu_pkg.sv @@
// Package for the keyed record hash table unit: sizes, codes and item types.
// Used by every module of the block except khtu_ram; depends on nothing.
`timescale 1ns / 1ps

package khtu_pkg;

  localparam int NUM_BUCKETS = 101;
  localparam int BUCKET_WAYS = 4;

  localparam int KEY_W   = 31;
  localparam int GRADE_W = 14;
  localparam int COUNT_W = 9;
  localparam int SUM_W   = 22;

  localparam int BKT_W     = $clog2(NUM_BUCKETS);
  localparam int FILL_W    = $clog2(BUCKET_WAYS + 1);
  localparam int WAY_W     = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int DSTEP_W   = $clog2(SUM_W + 1);

  // Scaled reciprocal of the bucket count: (key * HASH_RECIP) >> HASH_SHIFT is
  // the exact quotient for every key of KEY_W bits.
  localparam int HASH_SHIFT = KEY_W + BKT_W;
  localparam int RECIP_W    = KEY_W + 1;
  localparam logic [RECIP_W-1:0] HASH_RECIP =
    RECIP_W'(((64'd1 << HASH_SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

  localparam logic [GRADE_W-1:0] GRADE_MAX = 14'd10000;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_AVERAGE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_LOOK,
    ST_DIV
  } state_t;

  typedef struct packed {
    action_t              action;
    logic [KEY_W-1:0]     student_id;
    logic [GRADE_W-1:0]   grade_hundredths;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [GRADE_W-1:0]   found_grade;
    logic [GRADE_W-1:0]   average_hundredths;
    logic [COUNT_W-1:0]   entry_total;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]   id;
    logic [GRADE_W-1:0] grade;
  } way_t;

  typedef struct packed {
    logic [FILL_W-1:0]           fill;
    way_t [BUCKET_WAYS-1:0]      ways;
  } row_t;

endpackage

@@ src/keyed_record_hash_table_unit.sv @@
// Top level of the keyed record hash table unit: control, bucket store, counters.
// Depends on khtu_pkg, khtu_ram, khtu_hash, khtu_div and the assertion header.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; its one result shows on
// out_item for a single cycle with out_valid high and cannot be held off.
// Insert, remove and search pass through three steps in the bucket index unit
// (key load, reciprocal multiply, remainder), a bucket RAM read, and a step that
// modifies and writes back the bucket row. An average query runs the 22-step
// divider after its load, then the result register; on an empty table its result
// is registered directly at accept. Busy is high from the cycle after accept until
// the result is shown, except for an empty-table average, which never raises it,
// so the next item can be accepted in the same cycle that out_valid is high.
// Each RAM row holds one bucket with its fill count; a per-bucket valid flag
// cleared at reset marks the row empty, so no clearing pass is needed.

`include "keyed_record_hash_table_unit_defines.svh"

module keyed_record_hash_table_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  khtu_pkg::in_item_t    in_item,
  output logic                  out_valid,
  output khtu_pkg::out_item_t   out_item
);

  localparam int ROW_W = $bits(khtu_pkg::row_t);
  localparam int NW    = khtu_pkg::BUCKET_WAYS;

  khtu_pkg::state_t                 state_r, state_nxt;
  khtu_pkg::in_item_t               item_r, item_nxt;
  logic [khtu_pkg::BKT_W-1:0]       bucket_r, bucket_nxt;
  logic [khtu_pkg::NUM_BUCKETS-1:0] vld_r, vld_nxt;
  logic [khtu_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [khtu_pkg::COUNT_W-1:0]     cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  khtu_pkg::out_item_t              out_r, out_nxt;

  logic                             accept;
  logic                             hash_start, hash_done;
  logic [khtu_pkg::BKT_W-1:0]       hash_bucket;
  logic                             div_start, div_done;
  logic [khtu_pkg::SUM_W-1:0]       div_quo;
  logic                             ram_we, ram_re;
  khtu_pkg::row_t                   row_rd, row_cur, row_new;
  logic                             hit;
  logic [khtu_pkg::WAY_W-1:0]       hit_way;
  logic [khtu_pkg::GRADE_W-1:0]     grade_sat;

  assign accept = start && (state_r == khtu_pkg::ST_IDLE);
  assign busy   = (state_r != khtu_pkg::ST_IDLE);

  assign grade_sat = (in_item.grade_hundredths > khtu_pkg::GRADE_MAX) ?
                     khtu_pkg::GRADE_MAX : in_item.grade_hundredths;

  khtu_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hash_start),
    .key    (in_item.student_id),
    .done   (hash_done),
    .bucket (hash_bucket)
  );

  khtu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sum_r),
    .den   (cnt_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  khtu_ram #(
    .WIDTH (ROW_W),
    .DEPTH (khtu_pkg::NUM_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bucket_r),
    .wdata (row_new),
    .re    (ram_re),
    .raddr (hash_bucket),
    .rdata (row_rd)
  );

  // A bucket never written since reset reads as empty.
  always_comb begin
    row_cur = row_rd;
    if (!vld_r[bucket_r]) begin
      row_cur.fill = '0;
    end
  end

  // Newest match wins: scan from the oldest way down so way 0 has priority.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      if ((khtu_pkg::FILL_W'(w) < row_cur.fill) &&
          (row_cur.ways[w].id == item_r.student_id)) begin
        hit     = 1'b1;
        hit_way = khtu_pkg::WAY_W'(w);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      khtu_pkg::ST_IDLE: begin
        if (start) begin
          if (in_item.action != khtu_pkg::ACT_AVERAGE) begin
            state_nxt = khtu_pkg::ST_HASH;
          end else if (cnt_r != '0) begin
            state_nxt = khtu_pkg::ST_DIV;
          end
        end
      end
      khtu_pkg::ST_HASH: begin
        if (hash_done) begin
          state_nxt = khtu_pkg::ST_LOOK;
        end
      end
      khtu_pkg::ST_LOOK: begin
        state_nxt = khtu_pkg::ST_IDLE;
      end
      khtu_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = khtu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = khtu_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    item_nxt      = item_r;
    bucket_nxt    = bucket_r;
    vld_nxt       = vld_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    hash_start    = 1'b0;
    div_start     = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    row_new       = row_cur;

    case (state_r)
      khtu_pkg::ST_IDLE: begin
        if (accept) begin
          item_nxt                  = in_item;
          item_nxt.grade_hundredths = grade_sat;
          if (in_item.action != khtu_pkg::ACT_AVERAGE) begin
            hash_start = 1'b1;
          end else if (cnt_r != '0) begin
            div_start = 1'b1;
          end else begin
            out_valid_nxt              = 1'b1;
            out_nxt.status             = khtu_pkg::STS_EMPTY;
            out_nxt.found_grade        = '0;
            out_nxt.average_hundredths = '0;
            out_nxt.entry_total        = cnt_r;
          end
        end
      end
      khtu_pkg::ST_HASH: begin
        if (hash_done) begin
          ram_re     = 1'b1;
          bucket_nxt = hash_bucket;
        end
      end
      khtu_pkg::ST_LOOK: begin
        out_valid_nxt              = 1'b1;
        out_nxt.status             = khtu_pkg::STS_OK;
        out_nxt.found_grade        = '0;
        out_nxt.average_hundredths = '0;
        case (item_r.action)
          khtu_pkg::ACT_INSERT: begin
            if (row_cur.fill >= khtu_pkg::FILL_W'(NW)) begin
              out_nxt.status = khtu_pkg::STS_FULL;
            end else begin
              for (int w = 0; w < NW; w++) begin
                if (w == 0) begin
                  row_new.ways[w].id    = item_r.student_id;
                  row_new.ways[w].grade = item_r.grade_hundredths;
                end else begin
                  row_new.ways[w] = row_cur.ways[w-1];
                end
              end
              row_new.fill      = row_cur.fill + 1'b1;
              ram_we            = 1'b1;
              vld_nxt[bucket_r] = 1'b1;
              sum_nxt = sum_r + khtu_pkg::SUM_W'(item_r.grade_hundredths);
              cnt_nxt = cnt_r + 1'b1;
            end
          end
          khtu_pkg::ACT_REMOVE: begin
            if (!hit) begin
              out_nxt.status = khtu_pkg::STS_NOT_FOUND;
            end else begin
              // Ways after the match close up toward the head.
              for (int w = 0; w < NW; w++) begin
                if (khtu_pkg::WAY_W'(w) < hit_way) begin
                  row_new.ways[w] = row_cur.ways[w];
                end else if (w < NW - 1) begin
                  row_new.ways[w] = row_cur.ways[w+1];
                end else begin
                  row_new.ways[w] = '0;
                end
              end
              row_new.fill      = row_cur.fill - 1'b1;
              ram_we            = 1'b1;
              vld_nxt[bucket_r] = 1'b1;
              sum_nxt = sum_r - khtu_pkg::SUM_W'(row_cur.ways[hit_way].grade);
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          khtu_pkg::ACT_SEARCH: begin
            if (!hit) begin
              out_nxt.status = khtu_pkg::STS_NOT_FOUND;
            end else begin
              out_nxt.found_grade = row_cur.ways[hit_way].grade;
            end
          end
          default: begin
            out_nxt.status = khtu_pkg::STS_OK;
          end
        endcase
        out_nxt.entry_total = cnt_nxt;
      end
      khtu_pkg::ST_DIV: begin
        if (div_done) begin
          out_valid_nxt              = 1'b1;
          out_nxt.status             = khtu_pkg::STS_OK;
          out_nxt.found_grade        = '0;
          out_nxt.average_hundredths = div_quo[khtu_pkg::GRADE_W-1:0];
          out_nxt.entry_total        = cnt_r;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= khtu_pkg::ST_IDLE;
      vld_r       <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r   <= item_nxt;
    bucket_r <= bucket_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `KHTU_ASSERT_NXT(a_busy_after_work, accept && (in_item.action != khtu_pkg::ACT_AVERAGE), busy, "item accepted but block not busy")
  `KHTU_ASSERT_IMP(a_idle_on_result, out_valid, !busy, "result shown while block busy")
  `KHTU_ASSERT_IMP(a_bucket_range, hash_done, hash_bucket < khtu_pkg::BKT_W'(khtu_pkg::NUM_BUCKETS), "bucket index out of range")
  `KHTU_ASSERT_IMP(a_empty_sum, cnt_r == '0, sum_r == '0, "grade sum nonzero with no entries")

endmodule

@@ src/khtu_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependence.
`timescale 1ns / 1ps

module khtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/khtu_hash.sv @@
// Bucket index unit: key modulo the bucket count by reciprocal multiplication.
// Depends on khtu_pkg.
`timescale 1ns / 1ps

module khtu_hash (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [khtu_pkg::KEY_W-1:0]    key,
  output logic                          done,
  output logic [khtu_pkg::BKT_W-1:0]    bucket
);

  localparam int PROD_W = khtu_pkg::KEY_W + khtu_pkg::RECIP_W;
  localparam int QM_W   = 2 * khtu_pkg::BKT_W;

  logic [khtu_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [khtu_pkg::BKT_W-1:0]       qlo_r, qlo_nxt;
  logic [khtu_pkg::BKT_W-1:0]       rem_r, rem_nxt;
  logic                             mul_r, mul_nxt;
  logic                             sub_r, sub_nxt;
  logic                             done_r, done_nxt;
  logic [PROD_W-1:0]                prod;
  logic [QM_W-1:0]                  qmul;

  // The remainder fits in the index width, so only the low quotient bits are
  // needed and the subtraction wraps harmlessly at that width.
  always_comb begin
    prod     = PROD_W'(key_r) * PROD_W'(khtu_pkg::HASH_RECIP);
    qmul     = QM_W'(qlo_r) * QM_W'(khtu_pkg::NUM_BUCKETS);
    key_nxt  = start ? key : key_r;
    qlo_nxt  = prod[khtu_pkg::HASH_SHIFT +: khtu_pkg::BKT_W];
    rem_nxt  = key_r[khtu_pkg::BKT_W-1:0] - qmul[khtu_pkg::BKT_W-1:0];
    mul_nxt  = start;
    sub_nxt  = mul_r;
    done_nxt = sub_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      sub_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= mul_nxt;
      sub_r  <= sub_nxt;
      done_r <= done_nxt;
    end
    key_r <= key_nxt;
    qlo_r <= qlo_nxt;
    rem_r <= rem_nxt;
  end

  assign done   = done_r;
  assign bucket = rem_r;

endmodule

@@ src/khtu_div.sv @@
// Restoring divider for the average query, one quotient bit per cycle.
// Depends on khtu_pkg.
`timescale 1ns / 1ps

module khtu_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [khtu_pkg::SUM_W-1:0]    num,
  input  logic [khtu_pkg::COUNT_W-1:0]  den,
  output logic                          done,
  output logic [khtu_pkg::SUM_W-1:0]    quo
);

  logic [khtu_pkg::SUM_W-1:0]    num_r, num_nxt;
  logic [khtu_pkg::COUNT_W-1:0]  rem_r, rem_nxt;
  logic [khtu_pkg::COUNT_W-1:0]  den_r, den_nxt;
  logic [khtu_pkg::DSTEP_W-1:0]  cnt_r, cnt_nxt;
  logic                          run_r, run_nxt;
  logic                          done_r, done_nxt;
  logic [khtu_pkg::COUNT_W:0]    trial;
  logic                          qbit;

  always_comb begin
    trial = {rem_r, num_r[khtu_pkg::SUM_W-1]};
    qbit  = (trial >= {1'b0, den_r});
    if (qbit) begin
      trial = trial - {1'b0, den_r};
    end
  end

  // The dividend register shifts out its top bit and takes in the quotient bit.
  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = khtu_pkg::DSTEP_W'(khtu_pkg::SUM_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      num_nxt = {num_r[khtu_pkg::SUM_W-2:0], qbit};
      rem_nxt = trial[khtu_pkg::COUNT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == khtu_pkg::DSTEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

@@ bench/tb.sv @@
// Self-checking bench for keyed_record_hash_table_unit: directed and random commands.
// Depends on khtu_pkg and the unit's RTL; predicts each result and compares it.
`timescale 1ns / 1ps

module tb;
  import khtu_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  keyed_record_hash_table_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // Shadow copy of the bucket store.
  logic [KEY_W-1:0]   shadow_id    [NUM_BUCKETS][BUCKET_WAYS];
  logic [GRADE_W-1:0] shadow_grade [NUM_BUCKETS][BUCKET_WAYS];
  int unsigned        shadow_fill  [NUM_BUCKETS];
  logic [SUM_W-1:0]   shadow_sum;
  logic [COUNT_W-1:0] shadow_count;

  in_item_t  pending_cmds[$];
  out_item_t expected_results[$];
  int        mismatch_count;
  int        results_seen;
  int        gap_left;
  bit        hold_sender;
  int        full_hits, miss_hits, empty_hits;

  // Applies one command to the shadow table and returns its answer.
  function automatic out_item_t apply_command(in_item_t cmd);
    out_item_t res;
    int b, w, hit, n;
    logic [GRADE_W-1:0] g;
    res = '0;
    res.status = STS_OK;
    b = cmd.student_id % NUM_BUCKETS;
    g = (cmd.grade_hundredths > GRADE_MAX) ? GRADE_MAX : cmd.grade_hundredths;
    hit = BUCKET_WAYS;
    for (w = BUCKET_WAYS - 1; w >= 0; w--)
      if (w < shadow_fill[b] && shadow_id[b][w] == cmd.student_id) hit = w;
    case (cmd.action)
      ACT_INSERT: begin
        n = shadow_fill[b];
        if (n >= BUCKET_WAYS) begin
          res.status = STS_FULL;
        end else begin
          for (w = n; w > 0; w--) begin
            shadow_id[b][w] = shadow_id[b][w-1];
            shadow_grade[b][w] = shadow_grade[b][w-1];
          end
          shadow_id[b][0] = cmd.student_id;
          shadow_grade[b][0] = g;
          shadow_fill[b] = n + 1;
          shadow_sum += g;
          shadow_count++;
        end
      end
      ACT_REMOVE: begin
        if (hit == BUCKET_WAYS) begin
          res.status = STS_NOT_FOUND;
        end else begin
          shadow_sum -= shadow_grade[b][hit];
          shadow_count--;
          n = shadow_fill[b];
          for (w = hit; w + 1 < n; w++) begin
            shadow_id[b][w] = shadow_id[b][w+1];
            shadow_grade[b][w] = shadow_grade[b][w+1];
          end
          shadow_fill[b] = n - 1;
        end
      end
      ACT_SEARCH: begin
        if (hit == BUCKET_WAYS) res.status = STS_NOT_FOUND;
        else res.found_grade = shadow_grade[b][hit];
      end
      default: begin
        if (shadow_count == 0) res.status = STS_EMPTY;
        else res.average_hundredths = GRADE_W'(shadow_sum / shadow_count);
      end
    endcase
    res.entry_total = shadow_count;
    return res;
  endfunction

  function automatic in_item_t make_cmd(action_t act, logic [KEY_W-1:0] id,
                                        logic [GRADE_W-1:0] g);
    in_item_t c;
    c.action = act;
    c.student_id = id;
    c.grade_hundredths = g;
    return c;
  endfunction

  // Keys from a small pool land in few buckets, so hits and full buckets are common.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return KEY_W'($urandom_range(0, 5) + NUM_BUCKETS * $urandom_range(0, 5));
    if (r < 8) return KEY_W'({$urandom} >> 1);
    return KEY_W'(31'h7FFF_FFFF - $urandom_range(0, 3) * NUM_BUCKETS);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  // Driver: waits a random gap, then presents the next command until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      expected_results.push_back(apply_command(in_item));
      void'(pending_cmds.pop_front());
      if (pending_cmds.size() > 0 && !hold_sender && $urandom_range(0, 2) == 0) begin
        in_item <= pending_cmds[0];
        gap_left <= 0;
      end else begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 3);
      end
    end else if (!start && !hold_sender && pending_cmds.size() > 0) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else begin
        in_item <= pending_cmds[0];
        start <= 1'b1;
      end
    end
  end

  // Monitor: every strobed result must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", out_item);
      end else begin
        out_item_t exp_r;
        exp_r = expected_results.pop_front();
        if (out_item !== exp_r) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p, got %p", exp_r, out_item);
        end
        if (exp_r.status == STS_FULL) full_hits++;
        if (exp_r.status == STS_NOT_FOUND) miss_hits++;
        if (exp_r.status == STS_EMPTY) empty_hits++;
      end
    end
  end

  initial begin
    int i, r, k;
    logic [KEY_W-1:0] key;
    for (i = 0; i < NUM_BUCKETS; i++) shadow_fill[i] = 0;
    shadow_sum = '0;
    shadow_count = '0;
    mismatch_count = 0;
    results_seen = 0;
    full_hits = 0; miss_hits = 0; empty_hits = 0;
    hold_sender = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes, full bucket, duplicates, saturation.
    pending_cmds.push_back(make_cmd(ACT_AVERAGE, 31'h7FFF_FFFF, 14'h3FFF));
    pending_cmds.push_back(make_cmd(ACT_SEARCH, 31'd0, 14'd0));
    pending_cmds.push_back(make_cmd(ACT_REMOVE, 31'h7FFF_FFFF, 14'd0));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 31'd0, 14'd0));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 31'h7FFF_FFFF, 14'h3FFF));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 31'd101, 14'd10000));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 31'd0, 14'd10001));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 31'd202, 14'd1234));
    pending_cmds.push_back(make_cmd(ACT_INSERT, 31'd303, 14'd55));
    pending_cmds.push_back(make_cmd(ACT_SEARCH, 31'd0, 14'h3FFF));
    pending_cmds.push_back(make_cmd(ACT_SEARCH, 31'h7FFF_FFFF, 14'd0));
    pending_cmds.push_back(make_cmd(ACT_AVERAGE, 31'd5, 14'd7));
    pending_cmds.push_back(make_cmd(ACT_REMOVE, 31'd0, 14'h2AAA));
    pending_cmds.push_back(make_cmd(ACT_SEARCH, 31'd0, 14'd0));
    pending_cmds.push_back(make_cmd(ACT_REMOVE, 31'd0, 14'd0));
    pending_cmds.push_back(make_cmd(ACT_SEARCH, 31'd0, 14'd0));
    pending_cmds.push_back(make_cmd(ACT_REMOVE, 31'd202, 14'd0));
    pending_cmds.push_back(make_cmd(ACT_REMOVE, 31'd101, 14'd0));
    pending_cmds.push_back(make_cmd(ACT_REMOVE, 31'h7FFF_FFFF, 14'h1555));
    pending_cmds.push_back(make_cmd(ACT_AVERAGE, 31'd0, 14'd0));
    wait (pending_cmds.size() == 0 && expected_results.size() == 0);

    // Random phases; after the first the sender holds off until all results arrive.
    for (k = 0; k < 2; k++) begin
      for (i = 0; i < 915; i++) begin
        r = $urandom_range(0, 9);
        key = pick_key();
        if (r < 4)
          pending_cmds.push_back(make_cmd(ACT_INSERT, key,
            ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'($urandom_range(0, 10000))));
        else if (r < 6)
          pending_cmds.push_back(make_cmd(ACT_REMOVE, key, 14'($urandom)));
        else if (r < 9)
          pending_cmds.push_back(make_cmd(ACT_SEARCH, key, 14'($urandom)));
        else
          pending_cmds.push_back(make_cmd(ACT_AVERAGE, key, 14'($urandom)));
      end
      if (k == 0) begin
        wait (pending_cmds.size() == 0 && expected_results.size() == 0);
        hold_sender = 1'b1;
        repeat (30) @(posedge clk);
        hold_sender = 1'b0;
      end
    end
    wait (pending_cmds.size() == 0 && expected_results.size() == 0);
    repeat (40) @(posedge clk);

    $display("%0d results checked: %0d full-bucket, %0d not-found, %0d empty-table answers",
             results_seen, full_hits, miss_hits, empty_hits);
    $display("%0d records stored at end, %0d mismatches", shadow_count, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/khtu_pkg.sv
src/khtu_ram.sv
src/khtu_hash.sv
src/khtu_div.sv
src/keyed_record_hash_table_unit.sv
bench/tb.sv
